### hdl/gpna_pkg.sv
// Shared types, constants and state codes for the Gaussian pixel noise adder.
// No dependencies; imported by every module in hdl/.
package gpna_pkg;

  // Number formats
  localparam int UNIFORM_BITS = 16;
  localparam int FRAC_BITS    = 12;
  localparam int MAX_DRAWS    = 64;

  // Derived widths
  localparam int M_W    = UNIFORM_BITS + 1;          // |v| magnitude
  localparam int S_W    = 2 * UNIFORM_BITS;          // accepted radius s < 2^S_W
  localparam int SQ_W   = 2 * UNIFORM_BITS + 1;      // v^2
  localparam int NM_W   = (S_W > 32) ? S_W : 32;     // log mantissa register
  localparam int P_W    = 6;                         // msb position
  localparam int L_W    = 16 + P_W + 1;              // -log2 in Q16
  localparam int T_W    = 23;                        // -2 ln S in Q16
  localparam int Q_W    = 17;                        // v^2/s in Q16
  localparam int RAD_W  = 40;                        // sqrt radicand
  localparam int SQRT_STEPS = RAD_W / 2;
  localparam int DRAW_W = $clog2(MAX_DRAWS);
  localparam int SUM_W  = 34;
  localparam int VAL_W  = 44;
  localparam int MUL_W  = 35;
  localparam int PROD_W = 2 * MUL_W;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 32;

  localparam logic [16:0] TWO_LN2_Q16 = 17'd90852;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MEAN   = 4'd0,
    REG_DEV    = 4'd1,
    REG_GAIN   = 4'd2,
    REG_SEED   = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] pixel_value;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] noisy_pixel;
    logic       frame_end_out;
    logic       was_clamped;
  } out_item_t;

  // Control from the top level to the sequencer
  typedef struct packed {
    logic start;      // input transfer
    logic seed_load;  // seed register written
    logic take;       // output register can accept the result
  } core_ctl_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_GEN1, ST_GEN2, ST_SQ1, ST_SQ2, ST_SQ3, ST_NORM, ST_LSQ, ST_LACC,
    ST_LT1, ST_LT2, ST_DINIT, ST_DSTEP, ST_QT, ST_SQI, ST_SQRT, ST_SAMP,
    ST_MS1, ST_MS2, ST_MS3, ST_MS4, ST_DONE
  } st_t;

endpackage

### hdl/gpna_xorshift.sv
// 32-bit xorshift (13,17,5) uniform generator with seed load.
// Depends on gpna_pkg.
module gpna_xorshift import gpna_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic [31:0] seed,
  input  logic        step,
  output logic [31:0] nxt
);

  logic [31:0] state_r;
  logic [31:0] a, b;

  always_comb begin
    a   = state_r ^ (state_r << 13);
    b   = a ^ (a >> 17);
    nxt = b ^ (b << 5);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= 32'd1;
    end else if (load) begin
      state_r <= (seed == 32'd0) ? 32'd1 : seed;
    end else if (step) begin
      state_r <= nxt;
    end
  end

endmodule

### hdl/gpna_mul.sv
// Shared signed multiplier with registered product.
// Depends on gpna_pkg.
module gpna_mul import gpna_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

### hdl/gpna_core.sv
// Sequencer and datapath: polar draw, iterative log, divide, sqrt and noise sum.
// Depends on gpna_pkg, gpna_xorshift, gpna_mul.
module gpna_core import gpna_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  core_ctl_t           ctl,
  input  in_item_t            item,
  input  logic [31:0]         seed,
  input  logic signed [15:0]  mu,
  input  logic [15:0]         sigma,
  input  logic [7:0]          gain,
  output logic                busy,
  output logic                res_vld,
  output out_item_t           res
);

  st_t st_r, st_nxt;

  logic        gen_step;
  logic [31:0] gen_nxt;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  logic              phase_r;
  logic [DRAW_W-1:0] draws_r;
  logic [M_W-1:0]    m1_r, m2_r;
  logic              n1_r, n2_r;
  logic [SQ_W-1:0]   vsq1_r, vsq2_r;
  logic [S_W-1:0]    s_r;
  logic [NM_W-1:0]   nm_r;
  logic [P_W-1:0]    p_r;
  logic [15:0]       frac_r;
  logic [4:0]        it_r;
  logic [T_W-1:0]    t_r;
  logic [Q_W-1:0]    q_r;
  logic [S_W-1:0]    rem_r;
  logic [RAD_W-1:0]  rad_r, res_r, bit_r;
  logic              k_r;
  logic signed [15:0] x_r, second_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [7:0]        pix_r;
  logic              fe_r;
  out_item_t         out_r;

  // uniform to magnitude and sign
  logic [UNIFORM_BITS-1:0] u;
  logic [M_W:0]            twou;
  logic [M_W-1:0]          umag;
  logic                    uneg;

  logic [SQ_W:0]   s_sum;
  logic            s_ok;
  logic            norm_ok;
  logic [L_W-1:0]  l_val;
  logic [31:0]     mm;
  logic [SQ_W-1:0] dvd;
  logic            dge;
  logic [S_W:0]    rsh;
  logic [RAD_W-1:0] trial;
  logic [RAD_W-1:0] rsc;
  logic [14:0]     rmag;
  logic signed [15:0] xv;
  logic signed [VAL_W-1:0] val;

  localparam logic signed [VAL_W-1:0] VAL_TOP = VAL_W'(255) <<< (2 * FRAC_BITS);

  gpna_xorshift u_gen (
    .clk  (clk),
    .rst_n(rst_n),
    .load (ctl.seed_load),
    .seed (seed),
    .step (gen_step),
    .nxt  (gen_nxt)
  );

  gpna_mul u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (mul_b),
    .p  (prod)
  );

  always_comb begin
    u    = gen_nxt[31 -: UNIFORM_BITS];
    twou = {1'b0, u, 1'b0};
    uneg = ~u[UNIFORM_BITS-1];
    umag = uneg ? M_W'((M_W+1)'(1) << UNIFORM_BITS) - M_W'(twou)
                : M_W'(twou - ((M_W+1)'(1) << UNIFORM_BITS));
    s_sum   = (SQ_W+1)'(vsq1_r) + (SQ_W+1)'(prod[SQ_W-1:0]);
    s_ok    = (s_sum != '0) && (s_sum[SQ_W:S_W] == '0);
    norm_ok = (nm_r[NM_W-1:31] == '0) && nm_r[30];
    l_val   = (L_W'(S_W) << 16) - L_W'({p_r, frac_r});
    mm      = prod[61:30];
    dvd     = k_r ? vsq2_r : vsq1_r;
    dge     = dvd >= SQ_W'(s_r);
    rsh     = {rem_r, 1'b0};
    trial   = res_r + bit_r;
    rsc     = res_r >> (16 - FRAC_BITS);
    rmag    = (rsc > RAD_W'(32767)) ? 15'h7fff : rsc[14:0];
    xv      = (k_r ? n2_r : n1_r) ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
    val     = $signed(VAL_W'(pix_r) << (2 * FRAC_BITS)) + $signed(prod[VAL_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    gen_step = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    busy     = (st_r != ST_IDLE);
    res_vld  = 1'b0;
    unique case (st_r)
      ST_IDLE:  if (ctl.start) st_nxt = phase_r ? ST_MS1 : ST_GEN1;
      ST_GEN1: begin
        gen_step = 1'b1;
        st_nxt   = ST_GEN2;
      end
      ST_GEN2: begin
        gen_step = 1'b1;
        st_nxt   = ST_SQ1;
      end
      ST_SQ1: begin
        mul_a  = MUL_W'(m1_r);
        mul_b  = MUL_W'(m1_r);
        st_nxt = ST_SQ2;
      end
      ST_SQ2: begin
        mul_a  = MUL_W'(m2_r);
        mul_b  = MUL_W'(m2_r);
        st_nxt = ST_SQ3;
      end
      ST_SQ3: begin
        if (s_ok) st_nxt = ST_NORM;
        else if (draws_r == DRAW_W'(MAX_DRAWS - 1)) st_nxt = ST_MS1;
        else st_nxt = ST_GEN1;
      end
      ST_NORM:  if (norm_ok) st_nxt = ST_LSQ;
      ST_LSQ: begin
        mul_a  = MUL_W'(nm_r[30:0]);
        mul_b  = MUL_W'(nm_r[30:0]);
        st_nxt = ST_LACC;
      end
      ST_LACC:  st_nxt = (it_r == 5'd15) ? ST_LT1 : ST_LSQ;
      ST_LT1: begin
        mul_a  = MUL_W'(l_val);
        mul_b  = MUL_W'(TWO_LN2_Q16);
        st_nxt = ST_LT2;
      end
      ST_LT2:   st_nxt = ST_DINIT;
      ST_DINIT: st_nxt = ST_DSTEP;
      ST_DSTEP: if (it_r == 5'd15) st_nxt = ST_QT;
      ST_QT: begin
        mul_a  = MUL_W'(q_r);
        mul_b  = MUL_W'(t_r);
        st_nxt = ST_SQI;
      end
      ST_SQI:   st_nxt = ST_SQRT;
      ST_SQRT:  if (it_r == 5'(SQRT_STEPS - 1)) st_nxt = ST_SAMP;
      ST_SAMP:  st_nxt = k_r ? ST_MS1 : ST_DINIT;
      ST_MS1: begin
        mul_a  = MUL_W'(sigma);
        mul_b  = MUL_W'(x_r);
        st_nxt = ST_MS2;
      end
      ST_MS2:   st_nxt = ST_MS3;
      ST_MS3: begin
        mul_a  = MUL_W'(sum_r);
        mul_b  = MUL_W'(gain);
        st_nxt = ST_MS4;
      end
      ST_MS4:   st_nxt = ST_DONE;
      ST_DONE: begin
        if (ctl.take) begin
          res_vld = 1'b1;
          st_nxt  = ST_IDLE;
        end
      end
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // pair phase: flips per pixel, seed write restarts the pair
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else if (ctl.seed_load) begin
      phase_r <= 1'b0;
    end else if (st_r == ST_IDLE && ctl.start) begin
      phase_r <= ~phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r <= '0;
    end else if (st_r == ST_IDLE && ctl.start && !phase_r) begin
      second_r <= '0;
    end else if (st_r == ST_SAMP && k_r) begin
      second_r <= xv;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        pix_r   <= item.pixel_value;
        fe_r    <= item.frame_end;
        draws_r <= '0;
        k_r     <= 1'b0;
        x_r     <= phase_r ? second_r : 16'sd0;
      end
      ST_GEN1: begin
        m1_r <= umag;
        n1_r <= uneg;
      end
      ST_GEN2: begin
        m2_r <= umag;
        n2_r <= uneg;
      end
      ST_SQ2:  vsq1_r <= prod[SQ_W-1:0];
      ST_SQ3: begin
        vsq2_r  <= prod[SQ_W-1:0];
        s_r     <= s_sum[S_W-1:0];
        nm_r    <= NM_W'(s_sum[S_W-1:0]);
        p_r     <= P_W'(30);
        frac_r  <= '0;
        it_r    <= '0;
        draws_r <= draws_r + DRAW_W'(1);
      end
      ST_NORM: begin
        if (nm_r[NM_W-1:31] != '0) begin
          nm_r <= nm_r >> 1;
          p_r  <= p_r + P_W'(1);
        end else if (!nm_r[30]) begin
          nm_r <= nm_r << 1;
          p_r  <= p_r - P_W'(1);
        end
      end
      ST_LACC: begin
        frac_r <= {frac_r[14:0], mm[31]};
        nm_r   <= NM_W'(mm[31] ? (mm >> 1) : mm);
        it_r   <= (it_r == 5'd15) ? 5'd0 : it_r + 5'd1;
      end
      ST_LT2:  t_r <= prod[16 +: T_W];
      ST_DINIT: begin
        rem_r <= dge ? S_W'(dvd - SQ_W'(s_r)) : S_W'(dvd);
        q_r   <= Q_W'(dge);
        it_r  <= '0;
      end
      ST_DSTEP: begin
        if (rsh >= {1'b0, s_r}) begin
          rem_r <= S_W'(rsh - {1'b0, s_r});
          q_r   <= {q_r[Q_W-2:0], 1'b1};
        end else begin
          rem_r <= rsh[S_W-1:0];
          q_r   <= {q_r[Q_W-2:0], 1'b0};
        end
        it_r <= it_r + 5'd1;
      end
      ST_SQI: begin
        rad_r <= prod[RAD_W-1:0];
        res_r <= '0;
        bit_r <= RAD_W'(1) << (RAD_W - 2);
        it_r  <= '0;
      end
      ST_SQRT: begin
        if (rad_r >= trial) begin
          rad_r <= rad_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        it_r  <= it_r + 5'd1;
      end
      ST_SAMP: begin
        if (!k_r) begin
          x_r <= xv;
          k_r <= 1'b1;
        end
      end
      ST_MS2:  sum_r <= (SUM_W'(mu) <<< FRAC_BITS) + $signed(prod[SUM_W-1:0]);
      ST_MS4: begin
        out_r.frame_end_out <= fe_r;
        if (val < 0) begin
          out_r.noisy_pixel <= 8'd0;
          out_r.was_clamped <= 1'b1;
        end else if (val > VAL_TOP) begin
          out_r.noisy_pixel <= 8'd255;
          out_r.was_clamped <= 1'b1;
        end else begin
          out_r.noisy_pixel <= val[2*FRAC_BITS +: 8];
          out_r.was_clamped <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign res = out_r;

`ifndef SYNTHESIS
  a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE && ctl.start) |=> (st_r != ST_IDLE))
    else $error("start did not leave idle");
  a_phase_flip: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE && ctl.start && !ctl.seed_load) |=> (phase_r != $past(phase_r)))
    else $error("pair phase did not advance");
  a_result_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> (st_r == ST_DONE && ctl.take))
    else $error("result outside done state");
  a_sqrt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SQRT) |-> (it_r < 5'(SQRT_STEPS)))
    else $error("sqrt step count overrun");
`endif

endmodule

### hdl/gaussian_pixel_noise_adder.sv
// Top level: channels, configuration registers and result register.
// Depends on gpna_pkg and gpna_core.
// Per pixel: the second pixel of a pair goes straight to the noise sum with the held sample;
// the first runs draw, normalize, log and scale, divide and sqrt for both samples, noise sum,
// plus the normalize shifts and a redraw per rejected draw, up to 64 draws. One pixel at a time:
// the next input is taken once the result is in the result register; the shared multiplier,
// iterative log and one-bit-a-cycle divide and sqrt loops set the pace. in_stall follows busy.
// Reset (synchronous, rst_n low): registers to mean 4096, deviation 4096, gain 64,
// generator state 1, pair phase first, no result pending.
module gaussian_pixel_noise_adder import gpna_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_data
);

  logic signed [15:0] mean_r;
  logic [15:0]        dev_r;
  logic [7:0]         gain_r;
  logic [31:0]        seed_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  core_ctl_t ctl;
  logic      busy;
  logic      res_vld;
  out_item_t res;
  logic      cfg_wr;

  // config always accepted; write only while idle: the block itself does not enforce it
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  always_comb begin
    ctl.start     = in_valid & ~busy;
    ctl.seed_load = cfg_wr & (cfg_index == REG_SEED);
    // result register free or draining this cycle
    ctl.take      = ~out_valid_r | ~out_stall;
  end

  assign in_stall = busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= 16'sd4096;
      dev_r  <= 16'd4096;
      gain_r <= 8'd64;
      seed_r <= 32'd1;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_MEAN: mean_r <= $signed(cfg_data[15:0]);
        REG_DEV:  dev_r  <= cfg_data[15:0];
        REG_GAIN: gain_r <= cfg_data[7:0];
        REG_SEED: seed_r <= cfg_data;
        default:  ;
      endcase
    end
  end

  gpna_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .item   (in_data),
    .seed   (cfg_data),
    .mu     (mean_r),
    .sigma  (dev_r),
    .gain   (gain_r),
    .busy   (busy),
    .res_vld(res_vld),
    .res    (res)
  );

  // result register: holds a finished pixel until transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_vld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> (!out_valid_r || !out_stall))
    else $error("result overwrites pending transfer");
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("not busy after input transfer");
  a_seed_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && cfg_index == REG_SEED) |=> (seed_r == $past(cfg_data)))
    else $error("seed register not written");
`endif

endmodule

### tb/gpna_checker.sv
`timescale 1ns / 100ps
// Result checker for gaussian_pixel_noise_adder: tracks register writes and pixel transfers,
// predicts each noisy pixel and compares it with the result channel. Depends on gpna_pkg.
module gpna_checker import gpna_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_data,
  output int                    errors,
  output int                    pending
);

  logic signed [15:0] mu;
  logic [15:0]        sigma;
  logic [7:0]         gain;
  logic [31:0]        rng;
  logic               odd_pixel;
  logic signed [15:0] held_x;
  out_item_t          noisy_q[$];

  function automatic logic [31:0] xorshift(logic [31:0] x);
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

  // -log2(s / 2^32) in Q16
  function automatic logic [63:0] neg_log2(logic [63:0] s);
    logic [63:0] t, m;
    logic [63:0] p;
    logic [15:0] fr;
    t = s;
    p = 0;
    while (t > 1) begin
      t = t >> 1;
      p++;
    end
    m = (p <= 30) ? (s << (30 - p)) : (s >> (p - 30));
    fr = '0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      fr = {fr[14:0], 1'b0};
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        fr[0] = 1'b1;
      end
    end
    return (64'd32 << 16) - ((p << 16) | fr);
  endfunction

  function automatic logic [63:0] root(logic [63:0] a);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > a) b = b >> 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] gauss(logic [63:0] mag, logic neg, logic [63:0] s,
                                        logic [63:0] t16);
    logic [63:0] q, r;
    q = ((mag * mag) << 16) / s;  // same as the bitwise long division
    r = root(q * t16) >> (16 - FRAC_BITS);
    if (r > 32767) r = 32767;
    return neg ? 16'(-r) : 16'(r);
  endfunction

  // Next noise sample; draws a fresh pair on the first pixel of each pair
  task automatic next_noise(output logic signed [15:0] x);
    longint v1, v2;
    logic [63:0] m1, m2, s, t16;
    logic [15:0] first;
    if (!odd_pixel) begin
      first = '0;
      held_x = '0;
      for (int d = 0; d < MAX_DRAWS; d++) begin
        rng = xorshift(rng);
        v1 = 2 * longint'(rng[31:16]) - 65536;
        rng = xorshift(rng);
        v2 = 2 * longint'(rng[31:16]) - 65536;
        m1 = (v1 < 0) ? -v1 : v1;
        m2 = (v2 < 0) ? -v2 : v2;
        s = m1 * m1 + m2 * m2;
        if (s != 0 && s < (64'd1 << 32)) begin
          t16 = (neg_log2(s) * 64'd90852) >> 16;
          first = gauss(m1, v1 < 0, s, t16);
          held_x = gauss(m2, v2 < 0, s, t16);
          break;
        end
      end
      x = first;
      odd_pixel = 1'b1;
    end else begin
      x = held_x;
      odd_pixel = 1'b0;
    end
  endtask

  task automatic predict_pixel(in_item_t it);
    logic signed [15:0] x;
    longint sum, val;
    out_item_t e;
    next_noise(x);
    sum = longint'(mu) * 4096 + longint'(sigma) * longint'(x);
    val = (longint'(it.pixel_value) << 24) + sum * longint'(gain);
    e.frame_end_out = it.frame_end;
    if (val < 0) begin
      e.noisy_pixel = 8'd0;
      e.was_clamped = 1'b1;
    end else if (val > (longint'(255) << 24)) begin
      e.noisy_pixel = 8'd255;
      e.was_clamped = 1'b1;
    end else begin
      e.noisy_pixel = 8'(val >> 24);
      e.was_clamped = 1'b0;
    end
    noisy_q.push_back(e);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mu <= 16'sd4096;
      sigma <= 16'd4096;
      gain <= 8'd64;
      rng = 32'd1;
      odd_pixel = 1'b0;
      held_x = '0;
      noisy_q.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MEAN: mu <= cfg_data[15:0];
          REG_DEV:  sigma <= cfg_data[15:0];
          REG_GAIN: gain <= cfg_data[7:0];
          REG_SEED: begin
            rng = (cfg_data == 0) ? 32'd1 : cfg_data;
            odd_pixel = 1'b0;
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (noisy_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          errors <= errors + 1;
        end else begin
          out_item_t e;
          e = noisy_q.pop_front();
          if (e !== out_data) begin
            $display("%0t: mismatch, expected %p, got %p", $time, e, out_data);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && !in_stall) predict_pixel(in_data);
    end
    pending = noisy_q.size();
  end

endmodule

### tb/tb_gaussian_pixel_noise_adder.sv
`timescale 1ns / 100ps
// Stimulus and verdict for gaussian_pixel_noise_adder; the checker in gpna_checker does
// the prediction. Depends on gpna_pkg, gaussian_pixel_noise_adder and gpna_checker.
module tb_gaussian_pixel_noise_adder;
  import gpna_pkg::*;

  localparam int IDLE_LIMIT = 20000;  // cycles without any transfer before giving up
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  int                   errors;
  int                   pending;

  int   gap_pct = 0;    // sender idle chance per cycle
  int   stall_pct = 0;  // receiver stall chance per cycle
  logic hold_go = 1'b0;
  int   hold_left = 0;
  int   quiet = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  gaussian_pixel_noise_adder i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  gpna_checker i_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending
  );

  // Receiver: random stalls, or one long hold-off when asked
  always @(posedge clk) begin
    if (hold_go && hold_left == 0) hold_left = HOLD_CYCLES;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog on transfers of any kind
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // One register write; valid stays up for back-to-back writes
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic setup(logic [15:0] mu, logic [15:0] sigma, logic [7:0] k, logic [31:0] seed);
    write_reg(REG_MEAN, 32'(mu));
    write_reg(REG_DEV, 32'(sigma));
    write_reg(REG_GAIN, 32'(k));
    write_reg(REG_SEED, seed);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one pixel; sender gaps are taken before the transfer
  task automatic send(logic [7:0] pix, logic fe);
    in_item_t it;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    it.pixel_value = pix;
    it.frame_end = fe;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // Wait until every predicted pixel has come back
  task automatic drain();
    in_valid <= 1'b0;
    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    @(posedge clk);
  endtask

  task automatic random_pixels(int n);
    for (int i = 0; i < n; i++) send(8'($urandom_range(255)), $urandom_range(15) == 0);
  endtask

  initial begin
    int modes[4][2] = '{'{0, 0}, '{87, 0}, '{0, 87}, '{17, 17}};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: extremes of the pixel and the frame marker, across a few pairs
    send(8'd0, 1'b0);
    send(8'd255, 1'b0);
    send(8'd128, 1'b1);
    send(8'd1, 1'b0);
    send(8'd254, 1'b1);
    send(8'd127, 1'b0);
    drain();

    // Tiny positive noise on 255: sum just past the top still clamps
    setup(16'd1, 16'd0, 8'd1, 32'd7);
    send(8'd255, 1'b0);
    send(8'd254, 1'b0);
    drain();
    // Small negative mean on 0 clamps low
    setup(16'hFFFF, 16'd0, 8'd1, 32'hFFFF_FFFF);
    send(8'd0, 1'b1);
    send(8'd1, 1'b0);
    drain();
    // Zero seed loads as one; an out-of-range index changes nothing
    setup(16'd0, 16'd4096, 8'd4, 32'd0);
    write_reg(4'($urandom_range(15, 4)), $urandom);
    cfg_valid <= 1'b0;
    send(8'd100, 1'b0);
    send(8'd100, 1'b0);
    send(8'd100, 1'b1);
    drain();
    // Register extremes
    setup(16'h8000, 16'hFFFF, 8'd255, 32'h8000_0000);
    send(8'd50, 1'b0);
    send(8'd200, 1'b1);
    drain();
    setup(16'h7FFF, 16'hFFFF, 8'd0, 32'h1234_5678);
    send(8'd9, 1'b0);
    send(8'd250, 1'b1);
    drain();

    // Random phases under each idling mode
    for (int ph = 0; ph < 8; ph++) begin
      gap_pct = modes[ph % 4][0];
      stall_pct = modes[ph % 4][1];
      if (ph == 6)
        setup(16'($urandom), 16'($urandom), 8'($urandom), $urandom);
      else
        setup(16'($urandom_range(8192) - 4096), 16'($urandom_range(8192)),
              8'($urandom_range(16)), $urandom);
      random_pixels(110);
      drain();
    end

    // Receiver holds off while the sender keeps offering, filling the block
    gap_pct = 0;
    stall_pct = 0;
    setup(16'd0, 16'd2048, 8'd8, $urandom);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    random_pixels(20);
    drain();

    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### sim.f
hdl/gpna_pkg.sv
hdl/gpna_xorshift.sv
hdl/gpna_mul.sv
hdl/gpna_core.sv
hdl/gaussian_pixel_noise_adder.sv
tb/gpna_checker.sv
tb/tb_gaussian_pixel_noise_adder.sv
